// File: rtl/cda_pkg.sv
// shared types, codes and calendar helpers for the calendar date adder
// no dependencies; used by every module of the block
package cda_pkg;

	localparam int YEAR_BITS_DEF   = 16;
	localparam int AMOUNT_BITS_DEF = 16;

	// command codes (s_tuser)
	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_DAYS   = 2'd1;
	localparam logic [1:0] CMD_MONTHS = 2'd2;
	localparam logic [1:0] CMD_YEARS  = 2'd3;

	// status codes (m_tuser)
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_LOAD = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	localparam int         CYCLE_YEARS    = 400;
	localparam logic [8:0] MOD_LAST       = 9'(CYCLE_YEARS - 1);
	localparam int         RESET_YEAR     = 2000;
	localparam logic [8:0] RESET_YEAR_MOD = 9'(RESET_YEAR % CYCLE_YEARS);
	localparam logic [4:0] RESET_DAY      = 5'd1;
	localparam logic [3:0] RESET_MONTH    = 4'd1;
	localparam logic [3:0] LAST_MONTH     = 4'd12;

	// result of the year remainder unit
	typedef struct packed {
		logic       done;
		logic [8:0] rem;
	} cda_mod_res_t;

	// leap year from the year taken modulo 400
	function automatic logic leap_of(input logic [8:0] r);
		return (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
	endfunction

	function automatic logic [4:0] days_in(input logic [3:0] m, input logic lp);
		logic [4:0] d;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
			4'd2:                                       d = lp ? 5'd29 : 5'd28;
			default:                                    d = 5'd0;
		endcase
		return d;
	endfunction

endpackage

// File: rtl/cda_mod400.sv
// remainder unit: year modulo 400 by reciprocal multiplication, a quotient phase then a remainder phase
// depends on cda_pkg
module cda_mod400 #(
	parameter int YEAR_BITS = cda_pkg::YEAR_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [YEAR_BITS-1:0]   value,
	output cda_pkg::cda_mod_res_t  res
);

	// year / 400 = (year >> 4) / 25, the divide by 25 as a multiply and shift
	localparam int XW = YEAR_BITS - 4;
	localparam int RW = XW + 1;
	localparam int SH = XW + 5;
	localparam int PW = XW + RW;
	localparam int QW = PW - SH;
	localparam longint unsigned RECIP_L = ((64'd1 << SH) + 64'd24) / 64'd25;
	localparam logic [RW-1:0]   RECIP   = RW'(RECIP_L);
	localparam logic [8:0]      DIV_LO  = 9'(cda_pkg::CYCLE_YEARS);

	logic                 busy_q;
	logic                 phase_q;
	logic                 done_q;
	logic [YEAR_BITS-1:0] opnd_q;
	logic [QW-1:0]        quo_q;
	logic [8:0]           rem_q;
	logic [PW-1:0]        prod;

	assign prod = PW'(opnd_q[YEAR_BITS-1:4]) * PW'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= !start && busy_q && phase_q;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
			end else if (busy_q) begin
				if (phase_q)
					busy_q <= 1'b0;
				else
					phase_q <= 1'b1;
			end
		end
	end

	// first phase the quotient, second phase the remainder in 9-bit arithmetic
	always_ff @(posedge clk) begin
		if (start) begin
			opnd_q <= value;
		end else if (busy_q) begin
			if (phase_q)
				rem_q <= opnd_q[8:0] - 9'(quo_q) * DIV_LO;
			else
				quo_q <= prod[PW-1:SH];
		end
	end

	assign res.done = done_q;
	assign res.rem  = rem_q;

endmodule

// File: rtl/calendar_date_adder_core.sv
// top level of the calendar date adder: date registers and command sequencer
// depends on cda_pkg and cda_mod400
//
// usage
//   the block holds one gregorian date (reset: 1 january 2000) and takes one
//   command per input transfer on the s_ channel; each command produces
//   exactly one result transfer on the m_ channel with the new date and a
//   status (ok, invalid load rejected, year overflow saturated)
//   s_tuser carries the command: load, add days, add months, add years
// timing
//   add days / add months: one calendar step per cycle, fewer steps when
//   the year limit stops the steps early
//   load and add years: wait on the modulo-400 unit, which derives the
//   leap year of the new year
//   s_tready is high only while the sequencer is idle, so one command is
//   in flight at a time
// stalls
//   the result sits in an output register; a new command is taken while it
//   waits, but that command holds in its final step until m_tready frees
//   the register
// reset
//   arst_n clears the sequencer and the output valid and restores the date
module calendar_date_adder_core #(
	parameter int YEAR_BITS   = cda_pkg::YEAR_BITS_DEF,
	parameter int AMOUNT_BITS = cda_pkg::AMOUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // amount[15:0], load_day[20:16], load_month[24:21],
	                               // load_year[40:25], zero fill
	input  logic [1:0]  s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // day[4:0], month[8:5], year[24:9], zero fill
	output logic [1:0]  m_tuser    // status
);

	localparam int SW = ((YEAR_BITS > AMOUNT_BITS) ? YEAR_BITS : AMOUNT_BITS) + 1;
	localparam logic [YEAR_BITS-1:0] YEAR_MAX = {YEAR_BITS{1'b1}};

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_LOAD   = 3'd1;
	localparam logic [2:0] S_DAYS   = 3'd2;
	localparam logic [2:0] S_MONTHS = 3'd3;
	localparam logic [2:0] S_YSUM   = 3'd4;
	localparam logic [2:0] S_YMOD   = 3'd5;
	localparam logic [2:0] S_FINISH = 3'd6;

	logic [2:0]             state_q;
	logic [4:0]             day_q;
	logic [3:0]             month_q;
	logic [YEAR_BITS-1:0]   year_q;
	logic [8:0]             ymod_q;      // year_q modulo 400, kept in step with year_q
	logic [AMOUNT_BITS-1:0] cnt_q;       // steps left, or years to add
	logic [1:0]             status_q;
	logic [4:0]             ld_q;
	logic [3:0]             lm_q;
	logic                   ly_over_q;
	logic [YEAR_BITS-1:0]   ly_q;

	logic                   m_tvalid_q;
	logic [31:0]            m_tdata_q;
	logic [1:0]             m_tuser_q;

	// input field split
	logic [15:0]            in_amount;
	logic [4:0]             in_day;
	logic [3:0]             in_month;
	logic [15:0]            in_year;
	logic                   in_year_over;
	logic                   take;

	assign in_amount    = s_tdata[15:0];
	assign in_day       = s_tdata[20:16];
	assign in_month     = s_tdata[24:21];
	assign in_year      = s_tdata[40:25];
	assign in_year_over = (YEAR_BITS < 16) && ((32'(in_year) >> YEAR_BITS) != 32'd0);
	assign take         = s_tvalid && s_tready;

	// shared modulo-400 unit
	logic                   mod_start;
	logic [YEAR_BITS-1:0]   mod_value;
	cda_pkg::cda_mod_res_t  mod_res;

	// saturated year sum for add years
	logic [SW-1:0]          ysum;
	logic                   ysum_over;
	logic [YEAR_BITS-1:0]   ysat;

	assign ysum      = SW'(year_q) + SW'(cnt_q);
	assign ysum_over = ysum > SW'(YEAR_MAX);
	assign ysat      = ysum_over ? YEAR_MAX : ysum[YEAR_BITS-1:0];

	always_comb begin
		mod_start = 1'b0;
		mod_value = ysat;
		if (take && s_tuser == cda_pkg::CMD_LOAD) begin
			mod_start = 1'b1;
			mod_value = YEAR_BITS'(in_year);
		end else if (state_q == S_YSUM) begin
			mod_start = 1'b1;
		end
	end

	cda_mod400 #(
		.YEAR_BITS (YEAR_BITS)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.value  (mod_value),
		.res    (mod_res)
	);

	// calendar helpers for the current date
	logic                   cur_leap;
	logic [4:0]             cur_len;
	logic [4:0]             next_len;     // length of the following month, same year
	logic [8:0]             ymod_inc;
	logic                   new_leap;
	logic [4:0]             load_len;
	logic                   load_ok;
	logic [4:0]             ymod_len;     // length of current month in the new year

	assign cur_leap = cda_pkg::leap_of(ymod_q);
	assign cur_len  = cda_pkg::days_in(month_q, cur_leap);
	assign next_len = cda_pkg::days_in(month_q + 4'd1, cur_leap);
	assign ymod_inc = (ymod_q == cda_pkg::MOD_LAST) ? 9'd0 : ymod_q + 9'd1;
	assign new_leap = cda_pkg::leap_of(mod_res.rem);
	assign load_len = cda_pkg::days_in(lm_q, new_leap);
	assign ymod_len = cda_pkg::days_in(month_q, new_leap);
	assign load_ok  = (lm_q >= 4'd1) && (lm_q <= cda_pkg::LAST_MONTH) && (ld_q >= 5'd1)
		&& (ld_q <= load_len) && !ly_over_q;

	// output register frees when empty or taken this cycle
	logic out_free;
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			day_q      <= cda_pkg::RESET_DAY;
			month_q    <= cda_pkg::RESET_MONTH;
			year_q     <= YEAR_BITS'(cda_pkg::RESET_YEAR);
			ymod_q     <= cda_pkg::RESET_YEAR_MOD;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == S_FINISH && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						unique case (s_tuser)
							cda_pkg::CMD_LOAD:   state_q <= S_LOAD;
							cda_pkg::CMD_DAYS:   state_q <= S_DAYS;
							cda_pkg::CMD_MONTHS: state_q <= S_MONTHS;
							default:             state_q <= S_YSUM;
						endcase
					end
				end
				S_LOAD: begin
					if (mod_res.done) begin
						if (load_ok) begin
							day_q   <= ld_q;
							month_q <= lm_q;
							year_q  <= ly_q;
							ymod_q  <= mod_res.rem;
						end
						state_q <= S_FINISH;
					end
				end
				S_DAYS: begin
					if (cnt_q == '0) begin
						state_q <= S_FINISH;
					end else if (day_q < cur_len) begin
						day_q <= day_q + 5'd1;
					end else if (month_q < cda_pkg::LAST_MONTH) begin
						month_q <= month_q + 4'd1;
						day_q   <= 5'd1;
					end else if (year_q == YEAR_MAX) begin
						state_q <= S_FINISH;
					end else begin
						year_q  <= year_q + YEAR_BITS'(1);
						ymod_q  <= ymod_inc;
						month_q <= 4'd1;
						day_q   <= 5'd1;
					end
				end
				S_MONTHS: begin
					if (cnt_q == '0) begin
						state_q <= S_FINISH;
					end else if (month_q < cda_pkg::LAST_MONTH) begin
						month_q <= month_q + 4'd1;
						if (day_q > next_len)
							day_q <= next_len;
					end else if (year_q == YEAR_MAX) begin
						state_q <= S_FINISH;
					end else begin
						// january is 31 days, so the day never needs clamping here
						year_q  <= year_q + YEAR_BITS'(1);
						ymod_q  <= ymod_inc;
						month_q <= 4'd1;
					end
				end
				S_YSUM: begin
					year_q  <= ysat;
					state_q <= S_YMOD;
				end
				S_YMOD: begin
					if (mod_res.done) begin
						ymod_q <= mod_res.rem;
						if (day_q > ymod_len)
							day_q <= ymod_len;
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command payload and status, no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			cnt_q     <= AMOUNT_BITS'(in_amount);
			ld_q      <= in_day;
			lm_q      <= in_month;
			ly_q      <= YEAR_BITS'(in_year);
			ly_over_q <= in_year_over;
			status_q  <= cda_pkg::ST_OK;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (mod_res.done && !load_ok)
						status_q <= cda_pkg::ST_BAD_LOAD;
				end
				S_DAYS: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - AMOUNT_BITS'(1);
						if (day_q >= cur_len && month_q >= cda_pkg::LAST_MONTH
							&& year_q == YEAR_MAX)
							status_q <= cda_pkg::ST_OVERFLOW;
					end
				end
				S_MONTHS: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - AMOUNT_BITS'(1);
						if (month_q >= cda_pkg::LAST_MONTH && year_q == YEAR_MAX)
							status_q <= cda_pkg::ST_OVERFLOW;
					end
				end
				S_YSUM: begin
					if (ysum_over)
						status_q <= cda_pkg::ST_OVERFLOW;
				end
				default: ;
			endcase
		end
		if (state_q == S_FINISH && out_free) begin
			m_tdata_q <= {7'd0, 16'(year_q), month_q, day_q};
			m_tuser_q <= status_q;
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// File: rtl/cda_checker.sv
// port-level checks for calendar_date_adder_core, attached by bind
// depends on cda_pkg
module cda_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [47:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// a held result stays put until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// only one command in flight
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second command taken while busy");

	// result day and month lie in range; february is checked against 29 days in any year
	a_date: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[4:0] >= 5'd1 && m_tdata[8:5] >= 4'd1
			&& m_tdata[8:5] <= cda_pkg::LAST_MONTH
			&& m_tdata[4:0] <= cda_pkg::days_in(m_tdata[8:5], 1'b1))
		else $error("result date out of range");

	// status is one of the defined codes
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser == cda_pkg::ST_OK || m_tuser == cda_pkg::ST_BAD_LOAD
			|| m_tuser == cda_pkg::ST_OVERFLOW)
		else $error("undefined status code");

endmodule

bind calendar_date_adder_core cda_checker u_cda_checker (.*);

// File: sim/calendar_date_adder_core_test.sv
// self-checking testbench for calendar_date_adder_core: directed calendar corner cases,
// then about a thousand random commands with random stalls on both stream channels
// depends on cda_pkg and the calendar_date_adder_core rtl
module calendar_date_adder_core_test;
	import cda_pkg::*;

	localparam int unsigned YEAR_TOP      = (1 << YEAR_BITS_DEF) - 1;
	localparam int          SETTLE_CYCLES = 64;
	localparam int          RANDOM_COUNT  = 1000;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [47:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = CMD_LOAD;
	logic        m_tready = 1'b0;
	logic        s_tready;
	logic        m_tvalid;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;

	// no random idling on either channel while set
	bit quiet = 1'b0;
	// full-range day and month steps are slow, so only a few random ones
	int big_steps = 0;

	typedef struct {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [15:0] year;
		logic [1:0]  status;
	} calendar_result_t;

	class date_scoreboard;
		int unsigned      cur_day;
		int unsigned      cur_month;
		int unsigned      cur_year;
		calendar_result_t expected_dates[$];
		int               errors;

		function new();
			cur_day   = 1;
			cur_month = 1;
			cur_year  = 2000;
			errors    = 0;
		endfunction

		function bit is_leap(int unsigned y);
			return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		endfunction

		function int unsigned month_days(int unsigned y, int unsigned m);
			case (m)
				1, 3, 5, 7, 8, 10, 12: return 31;
				4, 6, 9, 11:           return 30;
				2:                     return is_leap(y) ? 29 : 28;
				default:               return 0;
			endcase
		endfunction

		// one day forward; 0 when already at the last day of the top year
		function bit advance_day();
			if (cur_day < month_days(cur_year, cur_month)) begin
				cur_day++;
				return 1'b1;
			end
			if (cur_month < 12) begin
				cur_month++;
				cur_day = 1;
				return 1'b1;
			end
			if (cur_year >= YEAR_TOP)
				return 1'b0;
			cur_year++;
			cur_month = 1;
			cur_day   = 1;
			return 1'b1;
		endfunction

		// one month forward, day clamped to the new month
		function bit advance_month();
			int unsigned lim;
			if (cur_month < 12) begin
				cur_month++;
			end else begin
				if (cur_year >= YEAR_TOP)
					return 1'b0;
				cur_year++;
				cur_month = 1;
			end
			lim = month_days(cur_year, cur_month);
			if (cur_day > lim)
				cur_day = lim;
			return 1'b1;
		endfunction

		function void note_command(logic [1:0] cmd, logic [15:0] amt, logic [4:0] ld,
		                           logic [3:0] lm, logic [15:0] ly);
			calendar_result_t res;
			int unsigned      sum;
			logic [1:0]       st;
			st = ST_OK;
			case (cmd)
				CMD_LOAD: begin
					if (lm >= 1 && lm <= 12 && ld >= 1 && ld <= month_days(ly, lm)) begin
						cur_day   = ld;
						cur_month = lm;
						cur_year  = ly;
					end else begin
						st = ST_BAD_LOAD;
					end
				end
				CMD_DAYS: begin
					for (int unsigned i = 0; i < amt; i++)
						if (!advance_day()) begin
							st = ST_OVERFLOW;
							break;
						end
				end
				CMD_MONTHS: begin
					for (int unsigned i = 0; i < amt; i++)
						if (!advance_month()) begin
							st = ST_OVERFLOW;
							break;
						end
				end
				default: begin
					sum = cur_year + amt;
					if (sum > YEAR_TOP) begin
						sum = YEAR_TOP;
						st  = ST_OVERFLOW;
					end
					cur_year = sum;
					if (cur_day > month_days(cur_year, cur_month))
						cur_day = month_days(cur_year, cur_month);
				end
			endcase
			res.day    = 5'(cur_day);
			res.month  = 4'(cur_month);
			res.year   = 16'(cur_year);
			res.status = st;
			expected_dates.push_back(res);
		endfunction

		function void check_result(logic [4:0] d, logic [3:0] m, logic [15:0] y,
		                           logic [1:0] st);
			calendar_result_t exp_res;
			if (expected_dates.size() == 0) begin
				$error("result with no command pending: %0d-%0d-%0d status %0d", y, m, d, st);
				errors++;
				return;
			end
			exp_res = expected_dates.pop_front();
			if (d !== exp_res.day) begin
				$error("day: expected %0d, got %0d", exp_res.day, d);
				errors++;
			end
			if (m !== exp_res.month) begin
				$error("month: expected %0d, got %0d", exp_res.month, m);
				errors++;
			end
			if (y !== exp_res.year) begin
				$error("year: expected %0d, got %0d", exp_res.year, y);
				errors++;
			end
			if (st !== exp_res.status) begin
				$error("status: expected %0d, got %0d", exp_res.status, st);
				errors++;
			end
		endfunction

		function int pending();
			return expected_dates.size();
		endfunction
	endclass

	date_scoreboard calendar;

	calendar_date_adder_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// result side back-pressure
	always @(posedge clk) begin
		m_tready <= quiet || ($urandom_range(99, 0) >= 13);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			calendar.check_result(m_tdata[4:0], m_tdata[8:5], m_tdata[24:9], m_tuser);
	end

	// one command transfer; valid stays high after it so back-to-back commands need no gap
	task automatic send_command(input logic [1:0] cmd, input logic [15:0] amt,
	                            input logic [4:0] ld, input logic [3:0] lm,
	                            input logic [15:0] ly);
		while (!quiet && $urandom_range(99, 0) < 13) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {7'd0, ly, lm, ld, amt};
		do @(posedge clk); while (!s_tready);
		calendar.note_command(cmd, amt, ld, lm, ly);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (calendar.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		#25_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		logic [1:0]  cmd;
		logic [15:0] amt;
		logic [4:0]  ld;
		logic [3:0]  lm;
		logic [15:0] ly;
		int unsigned roll;
		int unsigned mlen;

		calendar = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// zero amount leaves the reset date
		send_command(CMD_DAYS, 16'd0, 5'd0, 4'd0, 16'd0);
		// leap day of a 400 year, then add one year clamps to 28 february
		send_command(CMD_LOAD, 16'd0, 5'd29, 4'd2, 16'd2000);
		send_command(CMD_YEARS, 16'd1, 5'd0, 4'd0, 16'd0);
		// rejected loads: no leap day in a century year, day 0, day past month end,
		// month 0, month 13, all field bits high
		send_command(CMD_LOAD, 16'd0, 5'd29, 4'd2, 16'd1900);
		send_command(CMD_LOAD, 16'd0, 5'd0, 4'd5, 16'd2020);
		send_command(CMD_LOAD, 16'd0, 5'd31, 4'd4, 16'd2020);
		send_command(CMD_LOAD, 16'd0, 5'd1, 4'd0, 16'd2020);
		send_command(CMD_LOAD, 16'd0, 5'd15, 4'd13, 16'd2020);
		send_command(CMD_LOAD, 16'hffff, 5'd31, 4'd15, 16'hffff);
		// month step clamps 31 january into february
		send_command(CMD_LOAD, 16'd0, 5'd31, 4'd1, 16'd2021);
		send_command(CMD_MONTHS, 16'd1, 5'd0, 4'd0, 16'd0);
		// year rollover and leap day by day steps
		send_command(CMD_LOAD, 16'd0, 5'd31, 4'd12, 16'd2023);
		send_command(CMD_DAYS, 16'd1, 5'd0, 4'd0, 16'd0);
		send_command(CMD_LOAD, 16'd0, 5'd28, 4'd2, 16'd2024);
		send_command(CMD_DAYS, 16'd1, 5'd0, 4'd0, 16'd0);
		// day step past the last day of the top year
		send_command(CMD_LOAD, 16'd0, 5'd31, 4'd12, 16'(YEAR_TOP));
		send_command(CMD_DAYS, 16'd1, 5'd0, 4'd0, 16'd0);
		// month steps past december of the top year, day clamped on the way
		send_command(CMD_LOAD, 16'd0, 5'd31, 4'd10, 16'(YEAR_TOP));
		send_command(CMD_MONTHS, 16'd3, 5'd0, 4'd0, 16'd0);
		// year 0 up to the top year exactly, then one more saturates
		send_command(CMD_LOAD, 16'd0, 5'd1, 4'd1, 16'd0);
		send_command(CMD_YEARS, 16'hffff, 5'd0, 4'd0, 16'd0);
		send_command(CMD_YEARS, 16'd1, 5'd0, 4'd0, 16'd0);
		// saturated year is not a leap year, so the leap day clamps
		send_command(CMD_LOAD, 16'd0, 5'd29, 4'd2, 16'd2096);
		send_command(CMD_YEARS, 16'hffff, 5'd0, 4'd0, 16'd0);
		send_command(CMD_YEARS, 16'd0, 5'd0, 4'd0, 16'd0);
		// largest day and month amounts
		send_command(CMD_LOAD, 16'd0, 5'd1, 4'd1, 16'd2000);
		send_command(CMD_DAYS, 16'hffff, 5'd0, 4'd0, 16'd0);
		send_command(CMD_LOAD, 16'd0, 5'd15, 4'd6, 16'(YEAR_TOP - 1));
		send_command(CMD_MONTHS, 16'hffff, 5'd0, 4'd0, 16'd0);

		for (int n = 0; n < RANDOM_COUNT; n++) begin
			quiet = (n >= 300 && n < 500);
			if (n == 650)
				wait_drained();
			amt  = 16'($urandom);
			ld   = 5'($urandom);
			lm   = 4'($urandom);
			ly   = 16'($urandom);
			roll = $urandom_range(99, 0);
			if (roll < 22) begin
				cmd = CMD_LOAD;
				// most loads are valid dates, biased to month ends and the year limit
				if ($urandom_range(99, 0) >= 15) begin
					case ($urandom_range(3, 0))
						0:       ly = 16'(YEAR_TOP - $urandom_range(15, 0));
						1:       ly = 16'($urandom_range(655, 0) * 100);
						2:       ly = 16'($urandom_range(2100, 1890));
						default: ly = 16'($urandom);
					endcase
					lm   = 4'($urandom_range(12, 1));
					mlen = calendar.month_days(ly, lm);
					ld   = ($urandom_range(2, 0) == 0) ? 5'(mlen) : 5'($urandom_range(mlen, 1));
				end
			end else if (roll < 50) begin
				cmd  = CMD_DAYS;
				roll = $urandom_range(199, 0);
				if (roll == 0 && big_steps < 3)
					big_steps++;
				else if (roll < 40)
					amt = 16'($urandom_range(800, 0));
				else
					amt = 16'($urandom_range(40, 0));
			end else if (roll < 75) begin
				cmd  = CMD_MONTHS;
				roll = $urandom_range(199, 0);
				if (roll == 0 && big_steps < 3)
					big_steps++;
				else if (roll < 40)
					amt = 16'($urandom_range(400, 0));
				else
					amt = 16'($urandom_range(30, 0));
			end else begin
				cmd = CMD_YEARS;
				if ($urandom_range(1, 0) == 0)
					amt = 16'($urandom_range(100, 0));
			end
			send_command(cmd, amt, ld, lm, ly);
		end
		quiet = 1'b0;

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (calendar.errors == 0 && calendar.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
